@@ design/alm_pkg.sv @@
// shared types, constants and state codes for the audio level meter
`timescale 1ns / 1ps

package alm_pkg;

  // sample counter width, saturates at all ones
  localparam int COUNT_WIDTH = 32;

  localparam int FRAME_W  = 32;
  localparam int SAMPLE_W = 16;
  localparam int SUM_W    = 48;
  localparam int SQS_W    = 62;
  localparam int OUT_W    = 32;
  localparam int STEP_W   = 6;

  // iteration counts of the shared shift and subtract unit
  localparam int MEAN_STEPS = SUM_W;
  localparam int SQ_STEPS   = SQS_W;
  localparam int SQRT_STEPS = 16;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic                       opcode;
    logic signed [FRAME_W-1:0]  sample_frame;
  } alm_in_t;

  typedef struct packed {
    logic        [OUT_W-1:0]    window_samples;
    logic signed [SAMPLE_W-1:0] window_min;
    logic signed [SAMPLE_W-1:0] window_max;
    logic        [SAMPLE_W-1:0] window_peak;
    logic signed [SAMPLE_W-1:0] window_mean;
    logic        [SAMPLE_W-1:0] rms_level;
  } alm_out_t;

  // window accumulators as seen by the solver
  typedef struct packed {
    logic        [COUNT_WIDTH-1:0] count;
    logic signed [SUM_W-1:0]       sum;
    logic        [SQS_W-1:0]       square_sum;
    logic signed [SAMPLE_W-1:0]    min;
    logic signed [SAMPLE_W-1:0]    max;
    logic        [SAMPLE_W-1:0]    peak;
  } alm_stats_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_MEAN,
    ST_DIV_SQ,
    ST_SQRT,
    ST_FINISH
  } alm_state_t;

endpackage

@@ design/audio_level_meter_rms.sv @@
// top level of the audio level meter with min, max, peak, mean and rms
`timescale 1ns / 1ps
//
// usage
// - item channel (item_valid / item_stall / item): opcode add takes the
//   top 16 bits of sample_frame as a signed sample and folds it into the
//   window; opcode read requests the window statistics and clears it
// - a request is taken at a clock edge with valid high and stall low
// - add requests give no result; once the count is all ones, further
//   samples are dropped until the next read
// - a read computes its result in 48 steps of the shared shift/subtract
//   unit for the mean, 62 for the mean square and 16 for the square root,
//   then loads the output register; an empty window skips the steps and
//   loads all zeros
// - item_stall is high from the cycle after a read is taken until its
//   result is loaded, so no further request is taken until then
// - result channel (result_valid / result_stall / result): one result per
//   read, held in an output register until taken; add requests keep being
//   taken while a result waits, a new read finishes and then waits for it
// - rst (synchronous, active high) clears the window, the sequencer and
//   the result valid
//
module audio_level_meter_rms (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  alm_pkg::alm_in_t  item,
  output logic              result_valid,
  input  logic              result_stall,
  output alm_pkg::alm_out_t result
);
  import alm_pkg::*;

  logic                       accept;
  logic                       add_en;
  logic                       read_en;
  logic                       busy;
  logic signed [SAMPLE_W-1:0] sample;
  alm_stats_t                 stats;

  // the solver holds off new requests until its read is done
  assign item_stall = busy;
  assign accept     = item_valid && !item_stall;
  assign add_en     = accept && (item.opcode == OP_ADD);
  assign read_en    = accept && (item.opcode == OP_READ);

  // top half of the frame is the sample
  assign sample = item.sample_frame[FRAME_W-1 -: SAMPLE_W];

  // window clears on the same edge the solver snapshots it
  alm_window u_window (
    .clk      (clk),
    .rst      (rst),
    .add_en   (add_en),
    .clear_en (read_en),
    .sample   (sample),
    .stats    (stats)
  );

  alm_solver u_solver (
    .clk          (clk),
    .rst          (rst),
    .start        (read_en),
    .stats        (stats),
    .busy         (busy),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

@@ design/alm_window.sv @@
// window accumulators: count, sum, sum of squares, min, max, peak
`timescale 1ns / 1ps

module alm_window (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              add_en,
  input  logic                              clear_en,
  input  logic signed [alm_pkg::SAMPLE_W-1:0] sample,
  output alm_pkg::alm_stats_t               stats
);
  import alm_pkg::*;

  logic        [COUNT_WIDTH-1:0] count;
  logic signed [SUM_W-1:0]       sum;
  logic        [SQS_W-1:0]       square_sum;
  logic signed [SAMPLE_W-1:0]    min;
  logic signed [SAMPLE_W-1:0]    max;
  logic        [SAMPLE_W-1:0]    peak;

  logic                          full;
  logic signed [2*SAMPLE_W-1:0]  square;
  logic        [SAMPLE_W:0]      mag_wide;
  logic        [SAMPLE_W-1:0]    mag;

  assign full     = (count == {COUNT_WIDTH{1'b1}});
  assign square   = sample * sample;
  // magnitude in one extra bit so the most negative sample gives 32768
  assign mag_wide = sample[SAMPLE_W-1] ? ((SAMPLE_W+1)'(0) - {1'b1, sample})
                                       : {1'b0, sample};
  assign mag      = mag_wide[SAMPLE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst || clear_en) begin
      count      <= '0;
      sum        <= '0;
      square_sum <= '0;
      min        <= 16'sh7fff;
      max        <= 16'sh8000;
      peak       <= '0;
    end else if (add_en && !full) begin
      count      <= count + COUNT_WIDTH'(1);
      sum        <= sum + {{(SUM_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
      square_sum <= square_sum + {{(SQS_W-2*SAMPLE_W){1'b0}}, square};
      if (sample < min) min <= sample;
      if (sample > max) max <= sample;
      if (mag > peak)   peak <= mag;
    end
  end

  assign stats.count      = count;
  assign stats.sum        = sum;
  assign stats.square_sum = square_sum;
  assign stats.min        = min;
  assign stats.max        = max;
  assign stats.peak       = peak;

endmodule

@@ design/alm_solver.sv @@
// sequencer and shared shift/subtract unit for mean, mean square and rms
`timescale 1ns / 1ps

module alm_solver (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  alm_pkg::alm_stats_t stats,
  output logic                busy,
  output logic                result_valid,
  input  logic                result_stall,
  output alm_pkg::alm_out_t   result
);
  import alm_pkg::*;

  localparam logic [STEP_W-1:0] MEAN_LAST = STEP_W'(MEAN_STEPS - 1);
  localparam logic [STEP_W-1:0] SQ_LAST   = STEP_W'(SQ_STEPS - 1);
  localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(SQRT_STEPS - 1);

  alm_state_t state, state_next;

  logic [SQS_W-1:0]       work;
  logic [SQS_W-1:0]       square_snap;
  logic [OUT_W-1:0]       rem;
  logic [OUT_W-1:0]       div;
  logic [OUT_W-1:0]       root;
  logic [OUT_W-1:0]       sbit;
  logic [STEP_W-1:0]      cnt;
  logic [SAMPLE_W-1:0]    mean_mag;
  logic                   neg;
  logic                   empty;
  logic [OUT_W-1:0]       count_snap;
  logic [SAMPLE_W-1:0]    min_snap;
  logic [SAMPLE_W-1:0]    max_snap;
  logic [SAMPLE_W-1:0]    peak_snap;

  logic [OUT_W:0]         op_a;
  logic [OUT_W:0]         op_b;
  logic [OUT_W+1:0]       diff;
  logic                   ge;
  logic [SQS_W-1:0]       work_div;
  logic [OUT_W-1:0]       rem_div;
  logic [OUT_W-1:0]       root_step;
  logic [SUM_W-1:0]       sum_mag;
  logic                   load;

  assign sum_mag = stats.sum[SUM_W-1] ? (SUM_W'(0) - SUM_W'(stats.sum)) : SUM_W'(stats.sum);

  // shared compare and subtract
  always_comb begin
    case (state)
      ST_DIV_MEAN, ST_DIV_SQ: begin
        op_a = {rem, work[SQS_W-1]};
        op_b = {1'b0, div};
      end
      ST_SQRT: begin
        op_a = {1'b0, rem};
        op_b = {1'b0, root | sbit};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign diff      = {1'b0, op_a} - {1'b0, op_b};
  assign ge        = ~diff[OUT_W+1];
  assign work_div  = {work[SQS_W-2:0], ge};
  assign rem_div   = ge ? diff[OUT_W-1:0] : op_a[OUT_W-1:0];
  assign root_step = ge ? ((root >> 1) | sbit) : (root >> 1);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (start) state_next = (stats.count == '0) ? ST_FINISH : ST_DIV_MEAN;
      ST_DIV_MEAN: if (cnt == MEAN_LAST) state_next = ST_DIV_SQ;
      ST_DIV_SQ:   if (cnt == SQ_LAST) state_next = ST_SQRT;
      ST_SQRT:     if (cnt == SQRT_LAST) state_next = ST_FINISH;
      ST_FINISH:   if (load) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    busy = (state != ST_IDLE);
    load = (state == ST_FINISH) && (!result_valid || !result_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) result_valid <= 1'b1;
      else if (!result_stall) result_valid <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          count_snap  <= OUT_W'(stats.count);
          min_snap    <= stats.min;
          max_snap    <= stats.max;
          peak_snap   <= stats.peak;
          square_snap <= stats.square_sum;
          neg         <= stats.sum[SUM_W-1];
          empty       <= (stats.count == '0);
          work        <= {sum_mag, {(SQS_W-SUM_W){1'b0}}};
          rem         <= '0;
          div         <= OUT_W'(stats.count);
          cnt         <= '0;
        end
      end
      ST_DIV_MEAN: begin
        if (cnt == MEAN_LAST) begin
          mean_mag <= work_div[SAMPLE_W-1:0];
          work     <= square_snap;
          rem      <= '0;
          cnt      <= '0;
        end else begin
          work <= work_div;
          rem  <= rem_div;
          cnt  <= cnt + STEP_W'(1);
        end
      end
      ST_DIV_SQ: begin
        if (cnt == SQ_LAST) begin
          rem  <= work_div[OUT_W-1:0];
          root <= '0;
          sbit <= OUT_W'(1) << (2*SQRT_STEPS - 2);
          cnt  <= '0;
        end else begin
          work <= work_div;
          rem  <= rem_div;
          cnt  <= cnt + STEP_W'(1);
        end
      end
      ST_SQRT: begin
        if (ge) rem <= diff[OUT_W-1:0];
        root <= root_step;
        sbit <= sbit >> 2;
        cnt  <= cnt + STEP_W'(1);
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (load) begin
      if (empty) begin
        result <= '0;
      end else begin
        result.window_samples <= count_snap;
        result.window_min     <= min_snap;
        result.window_max     <= max_snap;
        result.window_peak    <= peak_snap;
        result.window_mean    <= neg ? (SAMPLE_W'(0) - mean_mag) : mean_mag;
        result.rms_level      <= root[SAMPLE_W-1:0];
      end
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> (state == ST_IDLE)) else $error("read accepted while solver busy");

  a_rem_below_div: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV_MEAN || state == ST_DIV_SQ) |-> (rem < div))
    else $error("partial remainder not below divisor");

  a_sqrt_bit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SQRT) |-> $onehot(sbit)) else $error("root bit not one-hot");

  a_rms_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && !empty) |-> (root <= OUT_W'(32768)))
    else $error("rms out of range");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> ($past(state) == ST_FINISH))
    else $error("result raised outside finish");

endmodule

@@ tb/tb.sv @@
// self-checking testbench for the audio level meter with min, max, peak, mean and rms
`timescale 1ns / 1ps

module tb;
  import alm_pkg::*;

  logic     clk;
  logic     rst;
  logic     item_valid;
  logic     item_stall;
  alm_in_t  item;
  logic     result_valid;
  logic     result_stall;
  alm_out_t result;

  audio_level_meter_rms dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // window predictor: mirrors the accumulators the block keeps between reads
  // ---------------------------------------------------------------------------
  logic [COUNT_WIDTH-1:0]    win_count;
  logic signed [SUM_W-1:0]   win_sum;
  logic [SQS_W-1:0]          win_sq;
  logic signed [SAMPLE_W-1:0] win_min;
  logic signed [SAMPLE_W-1:0] win_max;
  logic [SAMPLE_W-1:0]       win_peak;

  // statistics predicted for reads that were taken but not yet returned
  alm_out_t stats_pending[$];

  int mismatch_count;
  int samples_sent;
  int reads_sent;
  int results_checked;

  // sender pacing
  int burst_left;
  bit sender_gaps_on;

  function automatic void meter_clear();
    win_count = '0;
    win_sum   = '0;
    win_sq    = '0;
    win_min   = 16'sh7FFF;
    win_max   = -16'sh8000;
    win_peak  = '0;
  endfunction

  // bit-serial floor square root, 32-bit root of a 64-bit value
  function automatic logic [31:0] floor_root(input longint unsigned v);
    logic [31:0]      root;
    longint unsigned  trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = {32'b0, root | (32'd1 << b)};
      if (trial * trial <= v) root = root | (32'd1 << b);
    end
    return root;
  endfunction

  // fold one sample into the window; top 16 bits of the frame are the sample
  function automatic void meter_fold(input logic [FRAME_W-1:0] frame);
    logic signed [SAMPLE_W-1:0] s;
    int sv;
    int mag;
    s  = frame[31:16];
    sv = s;
    // saturated count: sample dropped until the window is read
    if (win_count == '1) return;
    win_count = win_count + 1'b1;
    win_sum   = win_sum + sv;
    win_sq    = win_sq + 62'(sv * sv);
    if (s < win_min) win_min = s;
    if (s > win_max) win_max = s;
    mag = (sv < 0) ? -sv : sv;
    if (mag > win_peak) win_peak = mag[15:0];
  endfunction

  // statistics a read returns, then the window starts over
  function automatic alm_out_t meter_readout();
    alm_out_t        r;
    longint          mean;
    longint unsigned mean_sq;
    logic [31:0]     rms;
    r = '0;
    if (win_count != '0) begin
      // signed division truncates toward zero, as the mean must
      mean    = longint'(win_sum) / longint'({32'b0, win_count});
      mean_sq = 64'(win_sq) / 64'(win_count);
      rms     = floor_root(mean_sq);
      r.window_samples = win_count;
      r.window_min     = win_min;
      r.window_max     = win_max;
      r.window_peak    = win_peak;
      r.window_mean    = mean[15:0];
      r.rms_level      = rms[15:0];
    end
    meter_clear();
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  // frame whose top half is the given sample and whose low half is noise
  function automatic logic [FRAME_W-1:0] frame_of(input logic signed [SAMPLE_W-1:0] s);
    return {s, 16'($urandom())};
  endfunction

  // one request: bursts with random gaps, drive at falling edge, taken at a
  // rising edge with stall low; the predictor advances on acceptance
  task automatic send_req(input logic op, input logic [FRAME_W-1:0] frame);
    alm_in_t req;
    int      gap;
    req.opcode       = op;
    req.sample_frame = frame;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = sender_gaps_on ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
        @(negedge clk);
        item_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    item_valid <= 1'b1;
    item       <= req;
    do @(posedge clk); while (item_stall);
    if (op == OP_ADD) begin
      meter_fold(frame);
      samples_sent++;
    end else begin
      stats_pending.push_back(meter_readout());
      reads_sent++;
    end
  endtask

  // drop valid and hold off until every predicted result has come back
  task automatic wait_drained();
    @(negedge clk);
    item_valid <= 1'b0;
    burst_left = 0;
    while (stats_pending.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // result side: stall pattern of its own, then the checker
  // ---------------------------------------------------------------------------

  // modes: never stall, random stalls, periodic stalls, long stall runs
  initial begin : receiver
    int mode;
    int span;
    int run;
    bit level;
    result_stall = 1'b0;
    run   = 0;
    level = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 300);
      for (int c = 0; c < span; c++) begin
        @(negedge clk);
        case (mode)
          0: result_stall <= 1'b0;
          1: result_stall <= ($urandom_range(0, 9) < 3);
          2: result_stall <= (c % 4 == 3);
          default: begin
            if (run == 0) begin
              level = ~level;
              run   = $urandom_range(1, 40);
            end
            run--;
            result_stall <= level;
          end
        endcase
      end
    end
  end

  task automatic check_field(input string label, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t ns: %s expected %0h actual %0h", $time, label, want, got);
    end
  endtask

  // each taken result against the oldest prediction
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (stats_pending.size() == 0) begin
        mismatch_count++;
        $display("%0t ns: result with none expected, actual %0h", $time, result);
      end else begin
        alm_out_t want;
        want = stats_pending.pop_front();
        results_checked++;
        check_field("window_samples", want.window_samples, result.window_samples);
        check_field("window_min", 32'(want.window_min), 32'(result.window_min));
        check_field("window_max", 32'(want.window_max), 32'(result.window_max));
        check_field("window_peak", 32'(want.window_peak), 32'(result.window_peak));
        check_field("window_mean", 32'(want.window_mean), 32'(result.window_mean));
        check_field("rms_level", 32'(want.rms_level), 32'(result.rms_level));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reads of an empty window give all zeros, frame content is ignored
  task automatic test_empty_reads();
    send_req(OP_READ, 32'h0000_0000);
    send_req(OP_READ, 32'hFFFF_FFFF);
  endtask

  // largest positive, most negative (peak 32768), minus one, zero with low bits set
  task automatic test_full_scale();
    send_req(OP_ADD, 32'h7FFF_FFFF);
    send_req(OP_READ, $urandom());
    send_req(OP_ADD, 32'h8000_0000);
    send_req(OP_ADD, 32'h8000_FFFF);
    send_req(OP_READ, $urandom());
    send_req(OP_ADD, 32'hFFFF_FFFF);
    send_req(OP_ADD, 32'h0000_FFFF);
    send_req(OP_ADD, 32'h8000_0000);
    send_req(OP_ADD, 32'h7FFF_0000);
    send_req(OP_READ, $urandom());
  endtask

  // mean of -3 and -4 truncates toward zero to -3, rms of 3 and 4 is 3
  task automatic test_mean_truncation();
    send_req(OP_ADD, frame_of(-16'sd3));
    send_req(OP_ADD, frame_of(-16'sd4));
    send_req(OP_READ, $urandom());
    send_req(OP_ADD, frame_of(16'sd3));
    send_req(OP_ADD, frame_of(16'sd4));
    send_req(OP_READ, $urandom());
  endtask

  // read right after a read (second one empty), then a full hold-off
  task automatic test_read_after_read();
    send_req(OP_ADD, frame_of(16'sd100));
    send_req(OP_ADD, frame_of(-16'sd250));
    send_req(OP_READ, $urandom());
    send_req(OP_READ, $urandom());
    wait_drained();
    send_req(OP_ADD, frame_of(-16'sd1));
    send_req(OP_READ, $urandom());
  endtask

  // sample for a random window in one of several shapes
  function automatic logic [FRAME_W-1:0] window_frame(input int shape,
                                                      input logic signed [15:0] base);
    logic signed [15:0] s;
    case (shape)
      0: return $urandom();
      1: s = 16'($urandom_range(0, 64)) - 16'sd32;
      2: s = base;
      3: begin
        case ($urandom_range(0, 3))
          0: s = 16'sh7FFF;
          1: s = -16'sh8000;
          2: s = -16'sh7FFF;
          default: s = -16'sd1;
        endcase
      end
      default: s = base + 16'($urandom_range(0, 16)) - 16'sd8;
    endcase
    return frame_of(s);
  endfunction

  // windows of random length and shape, each closed by a read; the count
  // cannot reach saturation in a run of this size
  task automatic test_random_windows(input int budget);
    int sent;
    int len;
    int pick;
    int shape;
    logic signed [15:0] base;
    sent = 0;
    while (sent < budget) begin
      sender_gaps_on = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 8)       len = 0;
      else if (pick < 80) len = $urandom_range(1, 16);
      else if (pick < 96) len = $urandom_range(17, 60);
      else                len = $urandom_range(100, 200);
      shape = $urandom_range(0, 4);
      base  = 16'($urandom());
      for (int k = 0; k < len; k++) send_req(OP_ADD, window_frame(shape, base));
      send_req(OP_READ, $urandom());
      sent += len + 1;
      if ($urandom_range(0, 15) == 0) wait_drained();
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst             = 1'b1;
    item_valid      = 1'b0;
    item            = '0;
    mismatch_count  = 0;
    samples_sent    = 0;
    reads_sent      = 0;
    results_checked = 0;
    burst_left      = 0;
    sender_gaps_on  = 1'b1;
    meter_clear();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_reads();
    test_full_scale();
    test_mean_truncation();
    test_read_after_read();
    test_random_windows(950);

    // all requests in: wait for the last statistics, then a read's latency
    wait_drained();
    repeat (200) @(posedge clk);
    if (stats_pending.size() != 0) mismatch_count++;

    $display("covered %0d samples and %0d reads (%0d results compared),",
             samples_sent, reads_sent, results_checked);
    $display("including empty windows, full-scale samples and back-to-back reads");
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // hard stop well beyond the slowest correct run
  initial begin
    #(20_000_000);
    $display("timeout with %0d results outstanding", stats_pending.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
